### design/plsg_pkg.sv
// plsg_pkg: shared constants, register indexes, controller states and the
// command/status structs that join the segmenter controller and datapath
// no dependencies
package plsg_pkg;

    localparam int MAX_LEN_DEF     = 254;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int TOL_BITS      = 24;
    localparam int ML_BITS       = 8;
    localparam int FRAC_BITS     = 8;
    localparam int LEN_OUT_BITS  = 8;
    localparam int RISE_OUT_BITS = 17;
    localparam int ERR_BITS      = 40;
    localparam int CFG_IDX_BITS  = 8;

    localparam logic [CFG_IDX_BITS-1:0] REG_TOLERANCE  = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_LENGTH = 8'd1;

    localparam logic [TOL_BITS-1:0] TOL_RESET = 24'd256;
    localparam logic [ML_BITS-1:0]  ML_RESET  = 8'd254;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_READ0,
        ST_XS,
        ST_WALK,
        ST_DRAIN,
        ST_DECIDE,
        ST_DIV,
        ST_COMMIT,
        ST_EMIT_CUT,
        ST_CUT_RD,
        ST_CUT_W0,
        ST_CUT_W1,
        ST_EMIT_FIN
    } state_t;

    typedef struct packed {
        logic take_in;
        logic first;
        logic rd0;
        logic load_xs;
        logic walk_issue;
        logic div_start;
        logic commit;
        logic load_out;
        logic out_fin;
        logic cut_rd;
        logic cut_w0;
        logic cut_w1;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic lim_ok;
        logic walk_last;
        logic pipe_busy;
        logic bound_busy;
        logic div_busy;
        logic accept_ok;
        logic fin;
    } stat_t;

endpackage

### design/plsg_ctrl.sv
// plsg_ctrl: sequencing state machine of the segmenter and the output word valid
// depends on plsg_pkg (state_t, cmd_t, stat_t)
module plsg_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  plsg_pkg::stat_t  stat,
    output plsg_pkg::cmd_t   cmd
);

    plsg_pkg::state_t state_reg;
    plsg_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != plsg_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= plsg_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            plsg_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = plsg_pkg::ST_START;
            end
            plsg_pkg::ST_START:
            begin
                if (stat.count_zero)
                    state_next = stat.fin ? plsg_pkg::ST_EMIT_FIN : plsg_pkg::ST_IDLE;
                else if (stat.lim_ok)
                    state_next = plsg_pkg::ST_READ0;
                else
                    state_next = plsg_pkg::ST_EMIT_CUT;
            end
            plsg_pkg::ST_READ0:  state_next = plsg_pkg::ST_XS;
            plsg_pkg::ST_XS:     state_next = plsg_pkg::ST_WALK;
            plsg_pkg::ST_WALK:
            begin
                if (stat.walk_last)
                    state_next = plsg_pkg::ST_DRAIN;
            end
            plsg_pkg::ST_DRAIN:
            begin
                if (!stat.pipe_busy && !stat.bound_busy)
                    state_next = plsg_pkg::ST_DECIDE;
            end
            plsg_pkg::ST_DECIDE:
            begin
                state_next = stat.accept_ok ? plsg_pkg::ST_DIV : plsg_pkg::ST_EMIT_CUT;
            end
            plsg_pkg::ST_DIV:
            begin
                if (!stat.div_busy)
                    state_next = plsg_pkg::ST_COMMIT;
            end
            plsg_pkg::ST_COMMIT:
            begin
                state_next = stat.fin ? plsg_pkg::ST_EMIT_FIN : plsg_pkg::ST_IDLE;
            end
            plsg_pkg::ST_EMIT_CUT:
            begin
                if (out_free)
                    state_next = plsg_pkg::ST_CUT_RD;
            end
            plsg_pkg::ST_CUT_RD: state_next = plsg_pkg::ST_CUT_W0;
            plsg_pkg::ST_CUT_W0: state_next = plsg_pkg::ST_CUT_W1;
            plsg_pkg::ST_CUT_W1:
            begin
                state_next = stat.fin ? plsg_pkg::ST_EMIT_FIN : plsg_pkg::ST_IDLE;
            end
            plsg_pkg::ST_EMIT_FIN:
            begin
                if (out_free)
                    state_next = plsg_pkg::ST_IDLE;
            end
            default:             state_next = plsg_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            plsg_pkg::ST_IDLE:   cmd.take_in = in_valid;
            plsg_pkg::ST_START:  cmd.first = stat.count_zero;
            plsg_pkg::ST_READ0:  cmd.rd0 = 1'b1;
            plsg_pkg::ST_XS:     cmd.load_xs = 1'b1;
            plsg_pkg::ST_WALK:   cmd.walk_issue = 1'b1;
            plsg_pkg::ST_DECIDE: cmd.div_start = stat.accept_ok;
            plsg_pkg::ST_COMMIT: cmd.commit = 1'b1;
            plsg_pkg::ST_EMIT_CUT:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            plsg_pkg::ST_CUT_RD: cmd.cut_rd = 1'b1;
            plsg_pkg::ST_CUT_W0: cmd.cut_w0 = 1'b1;
            plsg_pkg::ST_CUT_W1: cmd.cut_w1 = 1'b1;
            plsg_pkg::ST_EMIT_FIN:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.out_fin    = 1'b1;
                    cmd.clear      = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:             cmd = '0;
        endcase
    end

endmodule

### design/plsg_dp.sv
// plsg_dp: window store, error walk pipeline, serial bound multiplier,
// restoring divider, config registers and output word registers
// depends on plsg_pkg (constants, cmd_t, stat_t)
module plsg_dp
#(
    parameter int MAX_LEN     = plsg_pkg::MAX_LEN_DEF,
    parameter int SAMPLE_BITS = plsg_pkg::SAMPLE_BITS_DEF
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic signed [SAMPLE_BITS-1:0]             sample,
    input  logic                                      series_end,
    input  logic                                      cfg_wr,
    input  logic [plsg_pkg::CFG_IDX_BITS-1:0]         cfg_index,
    input  logic [plsg_pkg::TOL_BITS-1:0]             cfg_data,
    input  plsg_pkg::cmd_t                            cmd,
    output plsg_pkg::stat_t                           stat,
    output logic [plsg_pkg::LEN_OUT_BITS-1:0]         seg_length,
    output logic signed [plsg_pkg::RISE_OUT_BITS-1:0] seg_rise,
    output logic [plsg_pkg::ERR_BITS-1:0]             seg_err_sq,
    output logic                                      final_segment,
    output logic                                      run_last
);

    localparam int SB    = SAMPLE_BITS;
    localparam int DEPTH = MAX_LEN + 2;
    localparam int CW    = $clog2(MAX_LEN + 2);
    localparam int TW    = SB + CW + 3;
    localparam int HL    = TW / 2;
    localparam int HH    = TW - HL;
    localparam int SW    = 2 * TW + CW + 1;
    localparam int EB    = plsg_pkg::ERR_BITS;
    localparam int BW    = plsg_pkg::TOL_BITS + 3 * CW;
    localparam int CMPW  = SW + plsg_pkg::FRAC_BITS + BW;
    localparam int SATW  = SW + 2 * CW + EB + 1;
    localparam int DW    = SW + EB + 1;
    localparam int RW    = 2 * CW + 1;
    localparam int LW    = CW + plsg_pkg::ML_BITS;
    localparam int BND_START = plsg_pkg::TOL_BITS + 1;
    localparam int BCW   = $clog2(BND_START + 1);
    localparam int DCW   = $clog2(EB + 1);

    // config
    logic [plsg_pkg::TOL_BITS-1:0] tol_reg;
    logic [plsg_pkg::ML_BITS-1:0]  ml_reg;

    // window store
    logic signed [SB-1:0] win_mem [DEPTH];
    logic signed [SB-1:0] rdata_reg;
    logic                 we;
    logic                 re;
    logic [CW-1:0]        waddr;
    logic [CW-1:0]        raddr;
    logic signed [SB-1:0] wdata;

    // series state
    logic signed [SB-1:0] x_reg;
    logic                 fin_reg;
    logic [CW-1:0]        count_reg;
    logic signed [SB:0]   held_rise_reg;
    logic [EB-1:0]        held_err_reg;
    logic signed [SB-1:0] xs_reg;
    logic signed [SB:0]   rise_reg;

    // walk pipeline
    logic [CW-1:0]          k_reg;
    logic [CW-1:0]          k1_reg;
    logic                   v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [SB-1:0]   xk;
    logic signed [SB:0]     diff;
    logic signed [TW-1:0]   len_s;
    logic signed [TW-1:0]   k_s;
    logic signed [TW-1:0]   t_next;
    logic signed [TW-1:0]   t_reg;
    logic [TW-1:0]          a_abs;
    logic [HL-1:0]          a_lo;
    logic [HH-1:0]          a_hi;
    logic [2*HH-1:0]        pp_hh_reg;
    logic [HH+HL-1:0]       pp_hl_reg;
    logic [2*HL-1:0]        pp_ll_reg;
    logic [2*TW-1:0]        sq_next;
    logic [2*TW-1:0]        sq_reg;
    logic [SW-1:0]          acc_reg;

    // bound = tolerance * (len-1) * len^2
    logic [2*CW-1:0]                l2_reg;
    logic [BCW-1:0]                 bnd_cnt_reg;
    logic [BW-1:0]                  m_sh_reg;
    logic [plsg_pkg::TOL_BITS-1:0]  tol_sh_reg;
    logic [BW-1:0]                  bound_reg;

    // divider
    logic [DCW-1:0] div_cnt_reg;
    logic [RW-1:0]  rem_reg;
    logic [EB-1:0]  low_reg;
    logic [EB-1:0]  q_reg;
    logic           sat_reg;
    logic [RW-1:0]  rem_sh;
    logic           rem_ge;
    logic           sat_w;

    logic [LW-1:0] lim_eff;
    logic [LW-1:0] len_m1;

    // ---------------- config port ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= plsg_pkg::TOL_RESET;
            ml_reg  <= plsg_pkg::ML_RESET;
        end
        else if (cfg_wr)
        begin
            if (cfg_index == plsg_pkg::REG_TOLERANCE)
                tol_reg <= cfg_data;
            else if (cfg_index == plsg_pkg::REG_MAX_LENGTH)
                ml_reg <= cfg_data[plsg_pkg::ML_BITS-1:0];
        end
    end

    // ---------------- window store ----------------
    always_comb
    begin
        we    = 1'b0;
        waddr = '0;
        wdata = x_reg;
        re    = 1'b0;
        raddr = '0;
        if (cmd.first)
            we = 1'b1;
        if (cmd.commit)
        begin
            we    = 1'b1;
            waddr = count_reg;
        end
        if (cmd.cut_w0)
        begin
            we    = 1'b1;
            wdata = rdata_reg;
        end
        if (cmd.cut_w1)
        begin
            we    = 1'b1;
            waddr = CW'(1);
        end
        if (cmd.rd0)
            re = 1'b1;
        if (cmd.walk_issue)
        begin
            re    = 1'b1;
            raddr = k_reg;
        end
        if (cmd.cut_rd)
        begin
            re    = 1'b1;
            raddr = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            win_mem[waddr] <= wdata;
        if (re)
            rdata_reg <= win_mem[raddr];
    end

    // ---------------- series state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            held_rise_reg <= '0;
            held_err_reg  <= '0;
        end
        else
        begin
            if (cmd.first)
            begin
                count_reg     <= CW'(1);
                held_rise_reg <= '0;
                held_err_reg  <= '0;
            end
            if (cmd.commit)
            begin
                count_reg     <= count_reg + CW'(1);
                held_rise_reg <= rise_reg;
                held_err_reg  <= sat_reg ? {EB{1'b1}} : q_reg;
            end
            if (cmd.cut_w0)
            begin
                held_rise_reg <= (SB+1)'(x_reg) - (SB+1)'(rdata_reg);
                held_err_reg  <= '0;
            end
            if (cmd.cut_w1)
                count_reg <= CW'(2);
            if (cmd.clear)
            begin
                count_reg     <= '0;
                held_rise_reg <= '0;
                held_err_reg  <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            x_reg   <= sample;
            fin_reg <= series_end;
        end
        if (cmd.load_xs)
        begin
            xs_reg   <= rdata_reg;
            rise_reg <= (SB+1)'(x_reg) - (SB+1)'(rdata_reg);
        end
    end

    // ---------------- walk pipeline ----------------
    // the new end point is not in the store yet, it comes from x_reg
    assign xk     = (k1_reg == count_reg) ? x_reg : rdata_reg;
    assign diff   = (SB+1)'(xs_reg) - (SB+1)'(xk);
    assign len_s  = TW'($signed({1'b0, count_reg}));
    assign k_s    = TW'($signed({1'b0, k1_reg}));
    assign t_next = (len_s * TW'(diff)) + (TW'(rise_reg) * k_s);

    assign a_abs = t_reg[TW-1] ? TW'(-t_reg) : TW'(t_reg);
    assign a_lo  = a_abs[HL-1:0];
    assign a_hi  = a_abs[TW-1:HL];

    assign sq_next = ((2*TW)'(pp_hh_reg) << (2 * HL))
                   + ((2*TW)'(pp_hl_reg) << (HL + 1))
                   + (2*TW)'(pp_ll_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            k_reg  <= '0;
        end
        else
        begin
            v1_reg <= cmd.walk_issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            if (cmd.load_xs)
                k_reg <= '0;
            else if (cmd.walk_issue)
                k_reg <= k_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        k1_reg    <= k_reg;
        t_reg     <= t_next;
        pp_hh_reg <= (2*HH)'(a_hi) * (2*HH)'(a_hi);
        pp_hl_reg <= (HH+HL)'(a_hi) * (HH+HL)'(a_lo);
        pp_ll_reg <= (2*HL)'(a_lo) * (2*HL)'(a_lo);
        sq_reg    <= sq_next;
        if (cmd.load_xs)
            acc_reg <= '0;
        else if (v4_reg)
            acc_reg <= acc_reg + SW'(sq_reg);
    end

    // ---------------- bound, shift-add over tolerance bits ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bnd_cnt_reg <= '0;
        else if (cmd.load_xs)
            bnd_cnt_reg <= BCW'(BND_START);
        else if (bnd_cnt_reg != '0)
            bnd_cnt_reg <= bnd_cnt_reg - BCW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_xs)
            l2_reg <= (2*CW)'(count_reg) * (2*CW)'(count_reg);
        if (bnd_cnt_reg == BCW'(BND_START))
        begin
            m_sh_reg   <= BW'((3*CW)'(count_reg - CW'(1)) * (3*CW)'(l2_reg));
            tol_sh_reg <= tol_reg;
            bound_reg  <= '0;
        end
        else if (bnd_cnt_reg != '0)
        begin
            if (tol_sh_reg[0])
                bound_reg <= bound_reg + m_sh_reg;
            m_sh_reg   <= m_sh_reg << 1;
            tol_sh_reg <= tol_sh_reg >> 1;
        end
    end

    // ---------------- divider: err = acc / len^2 ----------------
    assign sat_w  = SATW'(acc_reg) >= (SATW'(l2_reg) << EB);
    assign rem_sh = {rem_reg[RW-2:0], low_reg[EB-1]};
    assign rem_ge = rem_sh >= RW'(l2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_cnt_reg <= '0;
        else if (cmd.div_start)
            div_cnt_reg <= DCW'(EB);
        else if (div_cnt_reg != '0)
            div_cnt_reg <= div_cnt_reg - DCW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            sat_reg <= sat_w;
            rem_reg <= RW'(DW'(acc_reg) >> EB);
            low_reg <= EB'(acc_reg);
            q_reg   <= '0;
        end
        else if (div_cnt_reg != '0)
        begin
            rem_reg <= rem_ge ? (rem_sh - RW'(l2_reg)) : rem_sh;
            q_reg   <= {q_reg[EB-2:0], rem_ge};
            low_reg <= low_reg << 1;
        end
    end

    // ---------------- output word ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            seg_length    <= plsg_pkg::LEN_OUT_BITS'(count_reg - CW'(1));
            seg_rise      <= plsg_pkg::RISE_OUT_BITS'(held_rise_reg);
            seg_err_sq    <= held_err_reg;
            final_segment <= cmd.out_fin;
            run_last      <= cmd.out_fin || !fin_reg;
        end
    end

    // ---------------- status ----------------
    always_comb
    begin
        lim_eff = LW'(ml_reg);
        if (ml_reg == '0)
            lim_eff = LW'(1);
        else if (LW'(ml_reg) > LW'(MAX_LEN))
            lim_eff = LW'(MAX_LEN);
    end

    assign len_m1 = LW'(count_reg - CW'(1));

    assign stat.count_zero = (count_reg == '0);
    assign stat.lim_ok     = len_m1 < lim_eff;
    assign stat.walk_last  = (k_reg == count_reg);
    assign stat.pipe_busy  = v1_reg || v2_reg || v3_reg || v4_reg;
    assign stat.bound_busy = (bnd_cnt_reg != '0);
    assign stat.div_busy   = (div_cnt_reg != '0);
    assign stat.accept_ok  = (CMPW'(acc_reg) << plsg_pkg::FRAC_BITS) <= CMPW'(bound_reg);
    assign stat.fin        = fin_reg;

endmodule

### design/piecewise_linear_segmenter.sv
// piecewise_linear_segmenter: streaming chord segmenter, one sample at a time.
// A sample that grows the window walks the error through one pipelined multiply-accumulate,
// waits on the serial bound multiply where it outlasts a short walk, then runs a 40-step
// divider and commits; a cut at the length limit skips the walk, a cut after the walk takes
// the place of divide and commit, a closing segment adds a final output word, and each output
// word waits while the output is stalled; the first sample of a series is only stored. One
// sample is in flight at a time. Reset clears control, counters, valid flags and held
// segment values and sets config defaults; datapath data and the window store are not cleared.
module piecewise_linear_segmenter
#(
    parameter int MAX_LEN     = plsg_pkg::MAX_LEN_DEF,
    parameter int SAMPLE_BITS = plsg_pkg::SAMPLE_BITS_DEF
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_stall,
    input  logic signed [SAMPLE_BITS-1:0]             sample,
    input  logic                                      series_end,
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic [plsg_pkg::LEN_OUT_BITS-1:0]         seg_length,
    output logic signed [plsg_pkg::RISE_OUT_BITS-1:0] seg_rise,
    output logic [plsg_pkg::ERR_BITS-1:0]             seg_err_sq,
    output logic                                      final_segment,
    output logic                                      run_last,
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [plsg_pkg::CFG_IDX_BITS-1:0]         cfg_index,
    input  logic [plsg_pkg::TOL_BITS-1:0]             cfg_data
);

    plsg_pkg::cmd_t  cmd;
    plsg_pkg::stat_t stat;

    // the user must change registers only while idle, the block itself does not enforce it; writes are always taken
    assign cfg_ready = 1'b1;

    plsg_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    plsg_dp
    #(
        .MAX_LEN     (MAX_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample        (sample),
        .series_end    (series_end),
        .cfg_wr        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .stat          (stat),
        .seg_length    (seg_length),
        .seg_rise      (seg_rise),
        .seg_err_sq    (seg_err_sq),
        .final_segment (final_segment),
        .run_last      (run_last)
    );

endmodule
